### design/thpl_pkg.sv
// ----------------------------------------------------------------------------
// thpl_pkg
// Shared types and constants of the thermistor polynomial linearizer.
// ----------------------------------------------------------------------------
package thpl_pkg;

   localparam int ADC_W      = 16;
   localparam int TEMP_W     = 13;
   localparam int COEF_W     = 14;
   localparam int ACC_W      = 32;
   localparam int XS_W       = 12;
   localparam int QUOT_W     = 14;
   localparam int PROD_W     = 30;
   localparam int NUM_COEF   = 6;
   localparam int MAX_ORDER  = NUM_COEF - 1;
   localparam int DEFAULT_POLY_ORDER = 5;

   localparam int Q_IN  = 11;
   localparam int Q_TMP = 6;

   localparam logic [QUOT_W-1:0] SCALE_MUL = 14'd8775;
   localparam logic [16:0]       SCALE_DIV = 17'd65535;

   localparam logic signed [ACC_W-1:0] TEMP_MAX = 32'sd4095;
   localparam logic signed [ACC_W-1:0] TEMP_MIN = -32'sd4096;

   localparam int PADDR_W  = 5;
   localparam int PDATA_W  = 32;
   localparam int REG_IDX_W = 3;

   typedef logic signed [COEF_W-1:0] coef_type;

   localparam coef_type COEF_RESET [NUM_COEF] = '{
      -14'sd1601, 14'sd4197, -14'sd4298, 14'sd2162, -14'sd622, 14'sd99
   };

   typedef struct packed {
      logic              valid;
      logic [ACC_W-1:0]  acc;
      logic [XS_W-1:0]   xs;
   } token_type;

endpackage

### design/thpl_channels.sv
// ----------------------------------------------------------------------------
// thpl_channels
// Valid/ready channel interfaces for the request and response sides.
// ----------------------------------------------------------------------------
interface thpl_req_if;
   logic                      valid;
   logic                      ready;
   logic [thpl_pkg::ADC_W-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface thpl_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [thpl_pkg::TEMP_W-1:0] temp_celsius;

   modport source (output valid, output temp_celsius, input ready);
   modport sink   (input valid, input temp_celsius, output ready);
endinterface

### design/thpl_csr.sv
// ----------------------------------------------------------------------------
// thpl_csr
// APB-style register file holding the six polynomial coefficients.
// ----------------------------------------------------------------------------
module thpl_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [thpl_pkg::PADDR_W-1:0]  paddr,
   input  logic [thpl_pkg::PDATA_W-1:0]  pwdata,
   output logic [thpl_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready,
   output thpl_pkg::coef_type            coef_o [thpl_pkg::NUM_COEF]
);

   thpl_pkg::coef_type               coef_ff [thpl_pkg::NUM_COEF];
   logic [thpl_pkg::REG_IDX_W-1:0]   reg_idx;
   logic                             wr_en;

   assign reg_idx = paddr[thpl_pkg::PADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < thpl_pkg::NUM_COEF; i++) begin
            coef_ff[i] <= thpl_pkg::COEF_RESET[i];
         end
      end else if (wr_en) begin
         for (int i = 0; i < thpl_pkg::NUM_COEF; i++) begin
            if (reg_idx == thpl_pkg::REG_IDX_W'(i)) begin
               coef_ff[i] <= pwdata[thpl_pkg::COEF_W-1:0];
            end
         end
      end
   end

   always_comb begin
      prdata = '0;
      for (int i = 0; i < thpl_pkg::NUM_COEF; i++) begin
         if (reg_idx == thpl_pkg::REG_IDX_W'(i)) begin
            prdata = thpl_pkg::PDATA_W'(coef_ff[i]);
         end
      end
   end

   assign coef_o = coef_ff;

endmodule

### design/thpl_scaler.sv
// ----------------------------------------------------------------------------
// thpl_scaler
// Two-stage front end that scales the ADC sample to the Q11 input value.
// ----------------------------------------------------------------------------
module thpl_scaler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic [thpl_pkg::ADC_W-1:0]         adc_sample,
   output logic                               ready_o,
   input  logic [thpl_pkg::ACC_W-1:0]         init_acc,
   output thpl_pkg::token_type                tok_o,
   input  logic                               ready_i
);

   logic                              s0_valid_ff, s0_valid_in;
   logic [thpl_pkg::PROD_W-1:0]       s0_prod_ff, s0_prod_in;
   thpl_pkg::token_type               s1_tok_ff, s1_tok_in;
   logic                              s0_load, s1_load;
   logic [thpl_pkg::QUOT_W-1:0]       quot_est;
   logic [16:0]                       rem_est;
   logic [thpl_pkg::QUOT_W-1:0]       quot;

   assign s1_load = !s1_tok_ff.valid || ready_i;
   assign s0_load = !s0_valid_ff || s1_load;
   assign ready_o = s0_load;

   // The remainder estimate stays below twice the divisor, so one correction suffices.
   always_comb begin
      quot_est = s0_prod_ff[thpl_pkg::PROD_W-1:16];
      rem_est  = {1'b0, s0_prod_ff[15:0]} + 17'(quot_est);
      quot     = quot_est + thpl_pkg::QUOT_W'(rem_est >= thpl_pkg::SCALE_DIV);
   end

   always_comb begin
      s0_valid_in = s0_valid_ff;
      s0_prod_in  = s0_prod_ff;
      if (s0_load) begin
         s0_valid_in = req_valid;
         s0_prod_in  = thpl_pkg::PROD_W'(adc_sample) * thpl_pkg::PROD_W'(thpl_pkg::SCALE_MUL);
      end
      s1_tok_in = s1_tok_ff;
      if (s1_load) begin
         s1_tok_in.valid = s0_valid_ff;
         s1_tok_in.acc   = init_acc;
         s1_tok_in.xs    = quot[thpl_pkg::QUOT_W-1:2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff     <= 1'b0;
         s1_tok_ff.valid <= 1'b0;
      end else begin
         s0_valid_ff     <= s0_valid_in;
         s1_tok_ff.valid <= s1_tok_in.valid;
      end
      s0_prod_ff    <= s0_prod_in;
      s1_tok_ff.acc <= s1_tok_in.acc;
      s1_tok_ff.xs  <= s1_tok_in.xs;
   end

   assign tok_o = s1_tok_ff;

endmodule

### design/thpl_horner_cell.sv
// ----------------------------------------------------------------------------
// thpl_horner_cell
// One Horner step: multiply by the input value, add the shifted coefficient
// and shift right arithmetically, split over a multiply and an add stage.
// ----------------------------------------------------------------------------
module thpl_horner_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  thpl_pkg::token_type        tok_i,
   output logic                       ready_o,
   input  thpl_pkg::coef_type         coef_i,
   output thpl_pkg::token_type        tok_o,
   input  logic                       ready_i
);

   thpl_pkg::token_type          m_tok_ff, m_tok_in;
   thpl_pkg::token_type          a_tok_ff, a_tok_in;
   logic                         m_load, a_load;
   logic [thpl_pkg::ACC_W-1:0]   coef_word;
   logic [thpl_pkg::ACC_W-1:0]   sum;

   assign a_load  = !a_tok_ff.valid || ready_i;
   assign m_load  = !m_tok_ff.valid || a_load;
   assign ready_o = m_load;

   assign coef_word = thpl_pkg::ACC_W'(coef_i) << (thpl_pkg::Q_IN + thpl_pkg::Q_TMP);
   assign sum       = m_tok_ff.acc + coef_word;

   always_comb begin
      m_tok_in = m_tok_ff;
      if (m_load) begin
         m_tok_in.valid = tok_i.valid;
         m_tok_in.acc   = tok_i.acc * thpl_pkg::ACC_W'(tok_i.xs);
         m_tok_in.xs    = tok_i.xs;
      end
      a_tok_in = a_tok_ff;
      if (a_load) begin
         a_tok_in.valid = m_tok_ff.valid;
         a_tok_in.acc   = thpl_pkg::ACC_W'($signed(sum) >>> thpl_pkg::Q_IN);
         a_tok_in.xs    = m_tok_ff.xs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_tok_ff.valid <= 1'b0;
         a_tok_ff.valid <= 1'b0;
      end else begin
         m_tok_ff.valid <= m_tok_in.valid;
         a_tok_ff.valid <= a_tok_in.valid;
      end
      m_tok_ff.acc <= m_tok_in.acc;
      m_tok_ff.xs  <= m_tok_in.xs;
      a_tok_ff.acc <= a_tok_in.acc;
      a_tok_ff.xs  <= a_tok_in.xs;
   end

   assign tok_o = a_tok_ff;

endmodule

### design/thermistor_poly_linearizer_top.sv
// ----------------------------------------------------------------------------
// thermistor_poly_linearizer_top
// Converts thermistor ADC samples to whole degrees Celsius with a Horner
// polynomial evaluated in a chain of pipelined cells.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake            Payload
//   req      in         valid/ready          adc_sample (16 bits unsigned)
//   rsp      out        valid/ready          temp_celsius (13 bits signed)
//   csr      in         APB psel/penable     six 14-bit coefficients
//
// One request is accepted per clock while a stage is empty or rsp is ready;
// each passes two scaling stages, two stages per Horner cell and the output
// register. Reset is synchronous and restores the default coefficients.
// A stalled response holds in the output register while earlier stages
// keep filling their empty slots, so requests are still taken.
// ----------------------------------------------------------------------------
module thermistor_poly_linearizer_top #(
   parameter int POLY_ORDER = thpl_pkg::DEFAULT_POLY_ORDER
) (
   input  logic                          clock,
   input  logic                          reset,
   thpl_req_if.sink                      req,
   thpl_rsp_if.source                    rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [thpl_pkg::PADDR_W-1:0]  paddr,
   input  logic [thpl_pkg::PDATA_W-1:0]  pwdata,
   output logic [thpl_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready
);

   thpl_pkg::coef_type              coef [thpl_pkg::NUM_COEF];
   thpl_pkg::coef_type              cell_coef [POLY_ORDER];
   thpl_pkg::token_type             tok [POLY_ORDER+1];
   logic                            rdy [POLY_ORDER+1];
   logic [thpl_pkg::ACC_W-1:0]      init_acc;
   logic                            out_valid_ff, out_valid_in;
   logic signed [thpl_pkg::TEMP_W-1:0] out_temp_ff, out_temp_in;
   logic signed [thpl_pkg::ACC_W-1:0]  final_val;
   logic                            out_load;

   thpl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .coef_o  (coef)
   );

   // Orders above the register set have no coefficient and count as zero.
   if (POLY_ORDER <= thpl_pkg::MAX_ORDER) begin : g_init_reg
      assign init_acc = thpl_pkg::ACC_W'(coef[thpl_pkg::MAX_ORDER-POLY_ORDER]) << thpl_pkg::Q_TMP;
   end else begin : g_init_zero
      assign init_acc = '0;
   end

   thpl_scaler u_scaler (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .adc_sample (req.adc_sample),
      .ready_o    (req.ready),
      .init_acc   (init_acc),
      .tok_o      (tok[0]),
      .ready_i    (rdy[0])
   );

   for (genvar i = 0; i < POLY_ORDER; i++) begin : g_cell
      localparam int ORDER = POLY_ORDER - 1 - i;
      if (ORDER <= thpl_pkg::MAX_ORDER) begin : g_coef_reg
         assign cell_coef[i] = coef[thpl_pkg::MAX_ORDER-ORDER];
      end else begin : g_coef_zero
         assign cell_coef[i] = '0;
      end

      thpl_horner_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_i   (tok[i]),
         .ready_o (rdy[i]),
         .coef_i  (cell_coef[i]),
         .tok_o   (tok[i+1]),
         .ready_i (rdy[i+1])
      );
   end

   assign out_load        = !out_valid_ff || rsp.ready;
   assign rdy[POLY_ORDER] = out_load;
   assign final_val       = $signed(tok[POLY_ORDER].acc) >>> thpl_pkg::Q_TMP;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_temp_in  = out_temp_ff;
      if (out_load) begin
         out_valid_in = tok[POLY_ORDER].valid;
         if (final_val > thpl_pkg::TEMP_MAX) begin
            out_temp_in = thpl_pkg::TEMP_W'(thpl_pkg::TEMP_MAX);
         end else if (final_val < thpl_pkg::TEMP_MIN) begin
            out_temp_in = thpl_pkg::TEMP_W'(thpl_pkg::TEMP_MIN);
         end else begin
            out_temp_in = thpl_pkg::TEMP_W'(final_val);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_temp_ff <= out_temp_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.temp_celsius = out_temp_ff;

endmodule
